>>> hdl/wff_pkg.sv
// Package: shared types, constants and conversion functions for the frame converter.
package wff_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 7;

    localparam logic [CfgIdxW-1:0] REG_FLOAT_FORMAT  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SAMPLE_BITS   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_STEREO_SOURCE = 2'd2;

    localparam logic [6:0] BITS_8  = 7'd8;
    localparam logic [6:0] BITS_16 = 7'd16;
    localparam logic [6:0] BITS_24 = 7'd24;
    localparam logic [6:0] BITS_32 = 7'd32;
    localparam logic [6:0] BITS_64 = 7'd64;

    localparam logic [31:0] POS_INF = 32'h7F80_0000;
    localparam logic [31:0] QNAN    = 32'h7FC0_0000;

    typedef struct packed {
        logic [63:0] left_raw;
        logic [63:0] right_raw;
        logic        first_frame;
    } in_word_t;

    typedef struct packed {
        logic [31:0] left_value;
        logic [31:0] right_value;
        logic [31:0] peak_value;
    } out_word_t;

    typedef struct packed {
        logic       float_format;
        logic [6:0] sample_bits;
        logic       stereo_source;
    } cfg_t;

    // leading one position of a 32-bit value
    function automatic logic [4:0] lead32(input logic [31:0] m);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // signed integer of 32 bits (sign extended), scaled by 2^-sc
    function automatic logic [31:0] pcm_to_single(input logic [31:0] v, input logic [4:0] sc);
        logic        s;
        logic [31:0] m;
        logic [4:0]  p;
        logic [31:0] al;
        logic [23:0] q;
        logic        g;
        logic        st;
        logic [8:0]  e;
        logic [24:0] qr;
        s = v[31];
        m = s ? (32'd0 - v) : v;
        if (m == 32'd0)
        begin
            return {s, 31'd0};
        end
        p = lead32(m);
        al = m << (5'd31 - p);
        q = al[31:8];
        g = al[7];
        st = |al[6:0];
        qr = {1'b0, q} + 25'(g && (st || q[0]));
        e = 9'd127 + 9'(p) - 9'(sc);
        if (qr[24])
        begin
            e = e + 9'd1;
        end
        return {s, e[7:0], qr[24] ? qr[23:1] : qr[22:0]};
    endfunction

    function automatic logic [31:0] dbl_to_single(input logic [63:0] d);
        logic         s;
        logic [10:0]  ex;
        logic [51:0]  fr;
        logic [12:0]  e;
        logic [52:0]  m;
        logic [23:0]  q;
        logic         g;
        logic         st;
        logic [24:0]  qr;
        logic [12:0]  sh;
        logic [105:0] w;
        s = d[63];
        ex = d[62:52];
        fr = d[51:0];
        if (ex == 11'h7FF)
        begin
            if (fr == 52'd0)
            begin
                return {s, POS_INF[30:0]};
            end
            return {s, QNAN[30:0] | {8'd0, fr[51:29]}};
        end
        if (ex == 11'd0)
        begin
            return {s, 31'd0};
        end
        e = 13'(ex) - 13'd896;
        m = {1'b1, fr};
        if (!e[12] && e != 13'd0)
        begin
            q = m[52:29];
            g = m[28];
            st = |m[27:0];
            qr = {1'b0, q} + 25'(g && (st || q[0]));
            if (qr[24])
            begin
                e = e + 13'd1;
            end
            if (e >= 13'd255)
            begin
                return {s, POS_INF[30:0]};
            end
            return {s, e[7:0], qr[24] ? qr[23:1] : qr[22:0]};
        end
        // subnormal result: mantissa lands 1 - e bits lower
        sh = 13'd0 - e;
        if (sh > 13'd23)
        begin
            return {s, 31'd0};
        end
        w = {m, 53'd0} >> sh[4:0];
        q = {1'b0, w[105:83]};
        g = w[82];
        st = |w[81:0];
        qr = {1'b0, q} + 25'(g && (st || q[0]));
        return {s, 31'(qr)};
    endfunction

endpackage

>>> hdl/wff_if.sv
// Interface: valid/ready stream channel carrying one word.
interface wff_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/wff_decode.sv
// Decoder: raw channel sample bytes to single-precision bits.
module wff_decode (
    input  wff_pkg::cfg_t cfg,
    input  logic [63:0]   raw,
    output logic [31:0]   value
);
    always_comb
    begin
        value = 32'd0;
        if (cfg.float_format)
        begin
            value = (cfg.sample_bits == wff_pkg::BITS_32) ? raw[31:0]
                                                          : wff_pkg::dbl_to_single(raw);
        end
        else
        begin
            unique case (cfg.sample_bits)
                wff_pkg::BITS_8:
                    value = wff_pkg::pcm_to_single({{24{~raw[7]}}, ~raw[7], raw[6:0]}, 5'd7);
                wff_pkg::BITS_16:
                    value = wff_pkg::pcm_to_single({{16{raw[15]}}, raw[15:0]}, 5'd15);
                wff_pkg::BITS_24:
                    value = wff_pkg::pcm_to_single({{8{raw[23]}}, raw[23:0]}, 5'd23);
                wff_pkg::BITS_32:
                    value = wff_pkg::pcm_to_single(raw[31:0], 5'd31);
                default:
                    value = 32'd0;
            endcase
        end
    end
endmodule

>>> hdl/wav_frame_to_float_core.sv
// Top level: WAV frame to single-precision converter with running peak.
// Stages: each frame passes through the input register, then the result register.
// Throughput: one frame per cycle; a full result register with a stalled sink
// holds the input register, and a new frame is taken whenever it can move.
// Reset: config returns to integer PCM, 16 bits, stereo; peak cleared to +0.0;
// both stages empty.
module wav_frame_to_float_core (
    input  logic        clk,
    input  logic        rst_n,
    wff_if.sink         in_ch,
    wff_if.source       out_ch,
    input  logic        cfg_we,
    input  logic [wff_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [wff_pkg::CfgDataW-1:0] cfg_data
);
    wff_pkg::cfg_t      cfg_reg;
    wff_pkg::in_word_t  in_reg;
    logic               in_vld_reg;
    wff_pkg::out_word_t out_reg;
    logic               out_vld_reg;
    logic [31:0]        peak_reg;
    logic [31:0]        peak_next;
    logic [31:0]        left_v;
    logic [31:0]        right_d;
    logic [31:0]        right_v;
    logic               adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{float_format: 1'b0, sample_bits: wff_pkg::BITS_16, stereo_source: 1'b1};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wff_pkg::REG_FLOAT_FORMAT:  cfg_reg.float_format <= cfg_data[0];
                wff_pkg::REG_SAMPLE_BITS:   cfg_reg.sample_bits <= cfg_data[6:0];
                wff_pkg::REG_STEREO_SOURCE: cfg_reg.stereo_source <= cfg_data[0];
                default: ;
            endcase
        end
    end

    wff_decode u_dec_l (.cfg(cfg_reg), .raw(in_reg.left_raw), .value(left_v));
    wff_decode u_dec_r (.cfg(cfg_reg), .raw(in_reg.right_raw), .value(right_d));

    assign right_v = cfg_reg.stereo_source ? right_d : left_v;
    assign adv = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || adv;

    always_comb
    begin
        logic [31:0] ml;
        logic [31:0] mr;
        ml = {1'b0, left_v[30:0]};
        mr = {1'b0, right_v[30:0]};
        peak_next = in_reg.first_frame ? 32'd0 : peak_reg;
        if (ml <= wff_pkg::POS_INF && ml > peak_next)
        begin
            peak_next = ml;
        end
        if (mr <= wff_pkg::POS_INF && mr > peak_next)
        begin
            peak_next = mr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            peak_reg <= 32'd0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
                peak_reg <= peak_next;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_reg <= in_ch.data;
        end
        if (adv)
        begin
            out_reg <= '{left_value: left_v, right_value: right_v, peak_value: peak_next};
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data = out_reg;
endmodule
